// File: rtl/tked_pkg.sv
`timescale 1ns / 1ps

package tked_pkg;

  // Key codes carried on key_code
  localparam logic [4:0] KC_CHAR       = 5'd0;
  localparam logic [4:0] KC_ENTER      = 5'd1;
  localparam logic [4:0] KC_CTRL_C     = 5'd2;
  localparam logic [4:0] KC_CTRL_D     = 5'd3;
  localparam logic [4:0] KC_BACKSPACE  = 5'd4;
  localparam logic [4:0] KC_DELETE     = 5'd5;
  localparam logic [4:0] KC_LEFT       = 5'd6;
  localparam logic [4:0] KC_RIGHT      = 5'd7;
  localparam logic [4:0] KC_UP         = 5'd8;
  localparam logic [4:0] KC_DOWN       = 5'd9;
  localparam logic [4:0] KC_HOME       = 5'd10;
  localparam logic [4:0] KC_END        = 5'd11;
  localparam logic [4:0] KC_CTRL_A     = 5'd12;
  localparam logic [4:0] KC_CTRL_E     = 5'd13;
  localparam logic [4:0] KC_CTRL_B     = 5'd14;
  localparam logic [4:0] KC_CTRL_F     = 5'd15;
  localparam logic [4:0] KC_CTRL_K     = 5'd16;
  localparam logic [4:0] KC_CTRL_U     = 5'd17;
  localparam logic [4:0] KC_CTRL_W     = 5'd18;
  localparam logic [4:0] KC_CTRL_P     = 5'd19;
  localparam logic [4:0] KC_CTRL_N     = 5'd20;
  localparam logic [4:0] KC_WORD_LEFT  = 5'd21;
  localparam logic [4:0] KC_WORD_RIGHT = 5'd22;
  localparam logic [4:0] KC_IGNORE     = 5'd23;
  localparam logic [4:0] KC_EOF        = 5'd24;

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;  // nothing pending
  localparam logic [2:0] PH_ESC   = 3'd1;  // after ESC
  localparam logic [2:0] PH_CSI   = 3'd2;  // after ESC [
  localparam logic [2:0] PH_SS3   = 3'd3;  // after ESC O
  localparam logic [2:0] PH_TILDE = 3'd4;  // after ESC [ digit, wants '~'
  localparam logic [2:0] PH_CSI1  = 3'd5;  // after ESC [ 1
  localparam logic [2:0] PH_MOD   = 3'd6;  // after ESC [ 1 ;
  localparam logic [2:0] PH_FINAL = 3'd7;  // after the modifier byte

  // Byte values of interest
  localparam logic [7:0] B_ESC    = 8'd27;
  localparam logic [7:0] B_DEL    = 8'd127;
  localparam logic [7:0] B_SPACE  = 8'h20;
  localparam logic [7:0] B_TAB    = 8'd9;
  localparam logic [7:0] B_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] B_UPPERO = 8'h4F;  // 'O'
  localparam logic [7:0] B_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] B_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] B_LOWB   = 8'h62;  // 'b'
  localparam logic [7:0] B_LOWF   = 8'h66;  // 'f'
  localparam logic [7:0] B_ONE    = 8'h31;  // '1'
  localparam logic [7:0] B_THREE  = 8'h33;  // '3'
  localparam logic [7:0] B_FOUR   = 8'h34;  // '4'
  localparam logic [7:0] B_SEVEN  = 8'h37;  // '7'
  localparam logic [7:0] B_EIGHT  = 8'h38;  // '8'
  localparam logic [7:0] B_UPA    = 8'h41;  // 'A'
  localparam logic [7:0] B_UPB    = 8'h42;  // 'B'
  localparam logic [7:0] B_UPC    = 8'h43;  // 'C'
  localparam logic [7:0] B_UPD    = 8'h44;  // 'D'
  localparam logic [7:0] B_UPF    = 8'h46;  // 'F'
  localparam logic [7:0] B_UPH    = 8'h48;  // 'H'

  // Final letter of CSI / SS3 cursor sequences
  function automatic logic [4:0] letter_key(input logic [7:0] b);
    logic [4:0] k;
    k = KC_IGNORE;
    case (b)
      B_UPA:   k = KC_UP;
      B_UPB:   k = KC_DOWN;
      B_UPC:   k = KC_RIGHT;
      B_UPD:   k = KC_LEFT;
      B_UPH:   k = KC_HOME;
      B_UPF:   k = KC_END;
      default: k = KC_IGNORE;
    endcase
    return k;
  endfunction

  // Single byte seen at idle (ESC handled by the caller)
  function automatic logic [4:0] idle_key(input logic [7:0] b);
    logic [4:0] k;
    k = KC_IGNORE;
    case (b)
      8'd1:    k = KC_CTRL_A;
      8'd2:    k = KC_CTRL_B;
      8'd3:    k = KC_CTRL_C;
      8'd4:    k = KC_CTRL_D;
      8'd5:    k = KC_CTRL_E;
      8'd6:    k = KC_CTRL_F;
      8'd8:    k = KC_BACKSPACE;
      8'd10:   k = KC_ENTER;
      8'd13:   k = KC_ENTER;
      8'd11:   k = KC_CTRL_K;
      8'd14:   k = KC_CTRL_N;
      8'd16:   k = KC_CTRL_P;
      8'd21:   k = KC_CTRL_U;
      8'd23:   k = KC_CTRL_W;
      B_DEL:   k = KC_BACKSPACE;
      default: k = (b >= B_SPACE || b == B_TAB) ? KC_CHAR : KC_IGNORE;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/terminal_key_escape_decoder_top.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_ready  | in_byte[7:0], end_of_input
// output   | out_valid / out_ready| key_code[4:0], char_value[7:0]
//
// One byte request per cycle sustained while the result side is not stalled;
// a key event's last byte is taken into the input register, decoded there and
// loaded into the result register, from which the event leaves.
// The decode is a single pass over the held byte and the phase register.
// Reset clears the phase, the pending key and both valid flags.
// A stalled result holds the byte in the input register; bytes that give
// no event pass through even while a result waits.
module terminal_key_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] key_code,
  output logic [7:0] char_value
);
  import tked_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eoi;

  // Parser state
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [4:0] pending_key;
  logic [4:0] pending_key_next;

  // Decode results
  logic       emit;
  logic [4:0] dec_key;
  logic [7:0] dec_char;
  logic       advance;

  // Advance the held byte when its event has somewhere to go
  assign advance  = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Decode of the held byte against the current phase
  always_comb begin
    emit             = 1'b1;
    dec_key          = KC_IGNORE;
    dec_char         = '0;
    phase_next       = PH_IDLE;
    pending_key_next = '0;
    if (s1_eoi) begin
      dec_key = (phase == PH_IDLE) ? KC_EOF : KC_IGNORE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (s1_byte == B_ESC) begin
            emit             = 1'b0;
            phase_next       = PH_ESC;
            pending_key_next = pending_key;
          end else begin
            dec_key = idle_key(s1_byte);
            if (dec_key == KC_CHAR) dec_char = s1_byte;
          end
        end
        PH_ESC: begin
          if (s1_byte == B_LBRACK || s1_byte == B_UPPERO) begin
            emit             = 1'b0;
            phase_next       = (s1_byte == B_LBRACK) ? PH_CSI : PH_SS3;
            pending_key_next = pending_key;
          end else if (s1_byte == B_LOWB) begin
            dec_key = KC_WORD_LEFT;
          end else if (s1_byte == B_LOWF) begin
            dec_key = KC_WORD_RIGHT;
          end
        end
        PH_CSI: begin
          if (s1_byte == B_ONE) begin
            emit             = 1'b0;
            phase_next       = PH_CSI1;
            pending_key_next = pending_key;
          end else if (s1_byte == B_THREE || s1_byte == B_FOUR ||
                       s1_byte == B_SEVEN || s1_byte == B_EIGHT) begin
            emit       = 1'b0;
            phase_next = PH_TILDE;
            if (s1_byte == B_THREE)      pending_key_next = KC_DELETE;
            else if (s1_byte == B_SEVEN) pending_key_next = KC_HOME;
            else                         pending_key_next = KC_END;
          end else begin
            dec_key = letter_key(s1_byte);
          end
        end
        PH_SS3: begin
          dec_key = letter_key(s1_byte);
        end
        PH_TILDE: begin
          if (s1_byte == B_TILDE) dec_key = pending_key;
        end
        PH_CSI1: begin
          if (s1_byte == B_TILDE) begin
            dec_key = KC_HOME;
          end else if (s1_byte == B_SEMI) begin
            emit             = 1'b0;
            phase_next       = PH_MOD;
            pending_key_next = pending_key;
          end
        end
        PH_MOD: begin
          // modifier byte: any value
          emit             = 1'b0;
          phase_next       = PH_FINAL;
          pending_key_next = pending_key;
        end
        PH_FINAL: begin
          if (s1_byte == B_UPC)      dec_key = KC_WORD_RIGHT;
          else if (s1_byte == B_UPD) dec_key = KC_WORD_LEFT;
        end
        default: begin
          dec_key = KC_IGNORE;
        end
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_eoi  <= end_of_input;
    end
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pending_key <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      pending_key <= pending_key_next;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      key_code   <= dec_key;
      char_value <= dec_char;
    end
  end

endmodule

// File: tb/terminal_key_escape_decoder_top_tb.sv
`timescale 1ns / 1ps

module terminal_key_escape_decoder_top_tb;
  import tked_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 1300;
  localparam int unsigned DRAIN_EVERY = 250;

  typedef struct packed {
    logic [4:0] key;
    logic [7:0] chr;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] key_code;
  logic [7:0] char_value;

  // decoder copy kept by the testbench
  logic [2:0] dec_phase = PH_IDLE;
  logic [4:0] dec_pending = '0;

  key_event_t  key_events_due[$];
  logic [7:0]  seq_bytes[$];
  bit          gaps_on = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned events_checked = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;

  terminal_key_escape_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_code     (key_code),
    .char_value   (char_value)
  );

  always #5 clk = ~clk;

  // Arrow / home / end letter after CSI or SS3
  function automatic logic [4:0] cursor_key_for(input logic [7:0] b);
    case (b)
      B_UPA:   return KC_UP;
      B_UPB:   return KC_DOWN;
      B_UPC:   return KC_RIGHT;
      B_UPD:   return KC_LEFT;
      B_UPH:   return KC_HOME;
      B_UPF:   return KC_END;
      default: return KC_IGNORE;
    endcase
  endfunction

  // Lone byte at idle; ESC is dealt with by the caller
  function automatic logic [4:0] plain_key_for(input logic [7:0] b);
    case (b)
      8'd1:    return KC_CTRL_A;
      8'd2:    return KC_CTRL_B;
      8'd3:    return KC_CTRL_C;
      8'd4:    return KC_CTRL_D;
      8'd5:    return KC_CTRL_E;
      8'd6:    return KC_CTRL_F;
      8'd8:    return KC_BACKSPACE;
      B_DEL:   return KC_BACKSPACE;
      8'd10:   return KC_ENTER;
      8'd13:   return KC_ENTER;
      8'd11:   return KC_CTRL_K;
      8'd14:   return KC_CTRL_N;
      8'd16:   return KC_CTRL_P;
      8'd21:   return KC_CTRL_U;
      8'd23:   return KC_CTRL_W;
      default: return (b >= B_SPACE || b == B_TAB) ? KC_CHAR : KC_IGNORE;
    endcase
  endfunction

  // Advance the decoder copy by one request; returns 1 when a key event results
  function automatic logic decode_byte(input logic [7:0] b, input logic eoi,
                                       output key_event_t ev);
    ev.key = KC_IGNORE;
    ev.chr = 8'd0;
    if (eoi) begin
      ev.key = (dec_phase == PH_IDLE) ? KC_EOF : KC_IGNORE;
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == B_ESC) begin
            dec_phase = PH_ESC;
            return 1'b0;
          end
          ev.key = plain_key_for(b);
          if (ev.key == KC_CHAR) ev.chr = b;
        end
        PH_ESC: begin
          if (b == B_LBRACK) begin
            dec_phase = PH_CSI;
            return 1'b0;
          end
          if (b == B_UPPERO) begin
            dec_phase = PH_SS3;
            return 1'b0;
          end
          if (b == B_LOWB) ev.key = KC_WORD_LEFT;
          else if (b == B_LOWF) ev.key = KC_WORD_RIGHT;
        end
        PH_CSI: begin
          if (b == B_ONE) begin
            dec_phase = PH_CSI1;
            return 1'b0;
          end
          if (b == B_THREE || b == B_FOUR || b == B_SEVEN || b == B_EIGHT) begin
            dec_pending = (b == B_THREE) ? KC_DELETE : (b == B_SEVEN) ? KC_HOME : KC_END;
            dec_phase = PH_TILDE;
            return 1'b0;
          end
          ev.key = cursor_key_for(b);
        end
        PH_SS3: ev.key = cursor_key_for(b);
        PH_TILDE: begin
          if (b == B_TILDE) ev.key = dec_pending;
        end
        PH_CSI1: begin
          if (b == B_TILDE) ev.key = KC_HOME;
          else if (b == B_SEMI) begin
            dec_phase = PH_MOD;
            return 1'b0;
          end
        end
        PH_MOD: begin
          // modifier value is not looked at
          dec_phase = PH_FINAL;
          return 1'b0;
        end
        default: begin
          if (b == B_UPC) ev.key = KC_WORD_RIGHT;
          else if (b == B_UPD) ev.key = KC_WORD_LEFT;
        end
      endcase
    end
    dec_phase = PH_IDLE;
    dec_pending = '0;
    return 1'b1;
  endfunction

  // Offer one request, with an optional random gap first; returns at the next falling edge
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    key_event_t ev;
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, eoi, ev)) key_events_due.push_back(ev);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_sequence();
    foreach (seq_bytes[i]) send_byte(seq_bytes[i], 1'b0);
  endtask

  // Hold off the sender until every key event has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (key_events_due.size() != 0) @(negedge clk);
  endtask

  // Fill seq_bytes with one complete escape sequence of random kind
  task automatic build_key_sequence();
    logic [7:0] letters[6] = '{B_UPA, B_UPB, B_UPC, B_UPD, B_UPH, B_UPF};
    logic [7:0] digits[5] = '{B_ONE, B_THREE, B_FOUR, B_SEVEN, B_EIGHT};
    int unsigned kind;
    kind = $urandom_range(0, 4);
    seq_bytes.delete();
    seq_bytes.push_back(B_ESC);
    case (kind)
      0: begin
        seq_bytes.push_back(B_LBRACK);
        seq_bytes.push_back(letters[$urandom_range(0, 5)]);
      end
      1: begin
        seq_bytes.push_back(B_UPPERO);
        seq_bytes.push_back(letters[$urandom_range(0, 5)]);
      end
      2: begin
        seq_bytes.push_back(B_LBRACK);
        seq_bytes.push_back(digits[$urandom_range(0, 4)]);
        seq_bytes.push_back(B_TILDE);
      end
      3: begin
        seq_bytes.push_back(B_LBRACK);
        seq_bytes.push_back(B_ONE);
        seq_bytes.push_back(B_SEMI);
        seq_bytes.push_back(8'($urandom_range(0, 255)));
        seq_bytes.push_back($urandom_range(0, 1) ? B_UPC : B_UPD);
      end
      default: seq_bytes.push_back($urandom_range(0, 1) ? B_LOWB : B_LOWF);
    endcase
  endtask

  // Extremes of the byte range and a few lone control keys
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(B_DEL, 1'b0);
    send_byte(B_TAB, 1'b0);
    send_byte(8'd3, 1'b0);
  endtask

  // One of each recognised escape form
  task automatic test_escape_sequences();
    seq_bytes = '{B_ESC, B_LBRACK, B_UPA};
    send_sequence();
    seq_bytes = '{B_ESC, B_UPPERO, B_UPF};
    send_sequence();
    seq_bytes = '{B_ESC, B_LBRACK, B_SEVEN, B_TILDE};
    send_sequence();
    seq_bytes = '{B_ESC, B_LBRACK, B_ONE, B_SEMI, 8'hFF, B_UPC};
    send_sequence();
    seq_bytes = '{B_ESC, B_LOWF};
    send_sequence();
  endtask

  // End of stream at idle and in the middle of a sequence
  task automatic test_end_of_input();
    send_byte(8'hFF, 1'b1);
    send_byte(B_ESC, 1'b0);
    send_byte(B_LBRACK, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // A second ESC breaks the sequence and is swallowed, not restarted
  task automatic test_broken_sequence();
    send_byte(B_ESC, 1'b0);
    send_byte(B_ESC, 1'b0);
    send_byte(B_UPA, 1'b0);
  endtask

  // Mix of lone bytes, whole sequences, cut-off sequences and stream ends
  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned start;
    int unsigned next_pause;
    int unsigned pick;
    int unsigned cut;
    start = bytes_sent;
    next_pause = start + DRAIN_EVERY;
    while (bytes_sent - start < n_bytes) begin
      // quiet stretch with no gaps on either side
      gaps_on = (bytes_sent - start < 500) || (bytes_sent - start >= 800);
      if (bytes_sent >= next_pause) begin
        wait_drained();
        next_pause += DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 70) begin
        build_key_sequence();
        send_sequence();
      end else if (pick < 88) begin
        build_key_sequence();
        cut = $urandom_range(1, seq_bytes.size() - 1);
        seq_bytes = seq_bytes[0:cut-1];
        send_sequence();
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        build_key_sequence();
        cut = $urandom_range(0, seq_bytes.size() - 1);
        if (cut == 0) seq_bytes.delete();
        else seq_bytes = seq_bytes[0:cut-1];
        send_sequence();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && (!gaps_on || $urandom_range(0, 99) >= 7);
  end

  // Compare each key event against the oldest one predicted
  always @(posedge clk) begin : check_events
    key_event_t due;
    if (!rst && out_valid && out_ready) begin
      if (key_events_due.size() == 0) begin
        if (failures < 10) $display("unexpected key event: key %0d char %0d", key_code, char_value);
        failures++;
      end else begin
        due = key_events_due.pop_front();
        events_checked++;
        if (key_code !== due.key || char_value !== due.chr) begin
          if (failures < 10)
            $display("mismatch: key exp %0d got %0d, char exp %0d got %0d",
                     due.key, key_code, due.chr, char_value);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_single_bytes();
    test_escape_sequences();
    test_end_of_input();
    test_broken_sequence();
    wait_drained();
    test_random_stream(RANDOM_BYTES);
    wait_drained();
    repeat (4) @(negedge clk);
    failures += key_events_due.size();
    $display("run covered %0d bytes: control keys, CSI/SS3/tilde/modifier forms, Alt moves,",
             bytes_sent);
    $display("cut-off sequences and end of stream; %0d key events checked, %0d failures",
             events_checked, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
